[design/rbsi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types and constants for the ray / box slab intersection unit.
// ----------------------------------------------------------------------------
package rbsi_pkg;

	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ORIGIN_X       = 3'd0,
		REG_ORIGIN_Y       = 3'd1,
		REG_ORIGIN_Z       = 3'd2,
		REG_INV_DIR_X      = 3'd3,
		REG_INV_DIR_Y      = 3'd4,
		REG_INV_DIR_Z      = 3'd5,
		REG_INTERVAL_START = 3'd6,
		REG_INTERVAL_END   = 3'd7
	} cfg_reg_t;

	// load enables of the slab stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} slab_en_t;

	// load enables of the merge stages
	typedef struct packed {
		logic s5;
		logic s6;
		logic s7;
	} merge_en_t;

endpackage

[design/rbsi_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_if
// Valid/ready channels: box items in, hit/interval items out.
// ----------------------------------------------------------------------------
interface rbsi_box_if #(
	parameter int COORD_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] box_min_x;
	logic signed [COORD_WIDTH-1:0] box_min_y;
	logic signed [COORD_WIDTH-1:0] box_min_z;
	logic signed [COORD_WIDTH-1:0] box_max_x;
	logic signed [COORD_WIDTH-1:0] box_max_y;
	logic signed [COORD_WIDTH-1:0] box_max_z;

	modport source (
		output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		input  ready
	);
	modport sink (
		input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		output ready
	);
endinterface

interface rbsi_result_if #(
	parameter int COORD_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic signed [COORD_WIDTH-1:0] t_near;
	logic signed [COORD_WIDTH-1:0] t_far;

	modport source (
		output valid, hit, t_near, t_far,
		input  ready
	);
	modport sink (
		input  valid, hit, t_near, t_far,
		output ready
	);
endinterface

[design/rbsi_slab.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_slab
// One axis: near and far slab parameters (bound - origin) * inv_dir,
// scaled down by FRAC_BITS toward zero and saturated. Four stages.
// ----------------------------------------------------------------------------
module rbsi_slab #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  rbsi_pkg::slab_en_t            en,
	input  logic signed [COORD_WIDTH-1:0] bmin,
	input  logic signed [COORD_WIDTH-1:0] bmax,
	input  logic signed [COORD_WIDTH-1:0] origin,
	input  logic signed [COORD_WIDTH-1:0] inv_dir,
	output logic signed [COORD_WIDTH-1:0] t_lo_s4,
	output logic signed [COORD_WIDTH-1:0] t_hi_s4
);
	import rbsi_pkg::*;

	localparam int W    = COORD_WIDTH;
	localparam int HALF = W / 2;
	localparam int HI   = W - HALF;
	localparam int DW   = W + 1;
	localparam int PW   = DW + W;
	localparam int QW   = PW - FRAC_BITS;
	localparam int EW   = (QW > W) ? QW : W + 1;
	localparam logic [W-1:0] TOP = {1'b1, {(W-1){1'b0}}};

	logic [W-1:0] imag_s1;
	logic         inv_neg;
	logic signed [W-1:0] bound [2];
	logic signed [W-1:0] slab_t [2];

	assign inv_neg  = inv_dir[W-1];
	assign bound[0] = inv_neg ? bmax : bmin;
	assign bound[1] = inv_neg ? bmin : bmax;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			imag_s1 <= inv_neg ? (~inv_dir + 1'b1) : inv_dir;
		end
	end

	for (genvar s = 0; s < 2; s++) begin : g_slab
		logic signed [DW-1:0] diff;
		logic [DW-1:0]        dmag_s1;
		logic                 neg_s1, neg_s2, neg_s3;
		logic [DW+HALF-1:0]   pp_lo_s2;
		logic [DW+HI-1:0]     pp_hi_s2;
		logic [PW-1:0]        prod_s3;
		logic [EW-1:0]        q_ext;
		logic [EW-1:0]        lim_ext;
		logic [W-1:0]         lim;
		logic [W-1:0]         q_sat;
		logic signed [W-1:0]  t_s4;

		assign diff = {bound[s][W-1], bound[s]} - {origin[W-1], origin};

		always_ff @(posedge clk) begin
			if (en.s1) begin
				dmag_s1 <= diff[DW-1] ? (~diff + 1'b1) : diff;
				neg_s1  <= diff[DW-1] ^ inv_neg;
			end
			if (en.s2) begin
				pp_lo_s2 <= (DW+HALF)'(dmag_s1) * (DW+HALF)'(imag_s1[HALF-1:0]);
				pp_hi_s2 <= (DW+HI)'(dmag_s1) * (DW+HI)'(imag_s1[W-1:HALF]);
				neg_s2   <= neg_s1;
			end
			if (en.s3) begin
				prod_s3 <= PW'(pp_lo_s2) + (PW'(pp_hi_s2) << HALF);
				neg_s3  <= neg_s2;
			end
			if (en.s4) begin
				t_s4 <= neg_s3 ? (~q_sat + 1'b1) : q_sat;
			end
		end

		// magnitude truncates toward zero; the negative side may reach one more
		assign lim     = neg_s3 ? TOP : TOP - 1'b1;
		assign q_ext   = EW'(prod_s3[PW-1:FRAC_BITS]);
		assign lim_ext = EW'(lim);
		assign q_sat   = (q_ext > lim_ext) ? lim : q_ext[W-1:0];
		assign slab_t[s] = t_s4;
	end

	assign t_lo_s4 = slab_t[0];
	assign t_hi_s4 = slab_t[1];

endmodule

[design/rbsi_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_merge
// Intersects the three slab intervals, checks against the ray interval
// and forms the result item. Three stages, the last is the output register.
// ----------------------------------------------------------------------------
module rbsi_merge #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  rbsi_pkg::merge_en_t           en,
	input  logic signed [COORD_WIDTH-1:0] lo_x,
	input  logic signed [COORD_WIDTH-1:0] hi_x,
	input  logic signed [COORD_WIDTH-1:0] lo_y,
	input  logic signed [COORD_WIDTH-1:0] hi_y,
	input  logic signed [COORD_WIDTH-1:0] lo_z,
	input  logic signed [COORD_WIDTH-1:0] hi_z,
	input  logic signed [COORD_WIDTH-1:0] t_start,
	input  logic signed [COORD_WIDTH-1:0] t_end,
	output logic                          hit_s7,
	output logic signed [COORD_WIDTH-1:0] t_near_s7,
	output logic signed [COORD_WIDTH-1:0] t_far_s7
);
	import rbsi_pkg::*;

	localparam int W = COORD_WIDTH;

	logic                miss_s5, miss_s6;
	logic signed [W-1:0] tmin_s5, tmax_s5, lo_z_s5, hi_z_s5;
	logic signed [W-1:0] tmin_s6, tmax_s6;
	logic                hit_c;

	always_ff @(posedge clk) begin
		if (en.s5) begin
			miss_s5 <= (lo_x > hi_y) || (lo_y > hi_x);
			tmin_s5 <= (lo_y > lo_x) ? lo_y : lo_x;
			tmax_s5 <= (hi_y < hi_x) ? hi_y : hi_x;
			lo_z_s5 <= lo_z;
			hi_z_s5 <= hi_z;
		end
		if (en.s6) begin
			miss_s6 <= miss_s5 || (tmin_s5 > hi_z_s5) || (lo_z_s5 > tmax_s5);
			tmin_s6 <= (lo_z_s5 > tmin_s5) ? lo_z_s5 : tmin_s5;
			tmax_s6 <= (hi_z_s5 < tmax_s5) ? hi_z_s5 : tmax_s5;
		end
		if (en.s7) begin
			hit_s7    <= hit_c;
			t_near_s7 <= hit_c ? tmin_s6 : t_start;
			t_far_s7  <= hit_c ? tmax_s6 : t_end;
		end
	end

	// entry strictly before interval end, exit strictly after its start
	assign hit_c = !miss_s6 && (tmin_s6 < t_end) && (tmax_s6 > t_start);

endmodule

[design/ray_box_slab_intersect_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_unit
// Slab test of one configured ray against a stream of axis-aligned boxes.
// ----------------------------------------------------------------------------
// Usage:
//  - Load the ray through cfg_we/cfg_index/cfg_data while no item is in
//    flight: origin, reciprocal direction per axis, interval start/end.
//  - box channel: one item per box (min and max per axis, signed fixed point).
//  - result channel: one item per box: hit, t_near, t_far. On a miss the
//    configured interval comes back unchanged.
// Timing:
//  - Seven register stages, s1 to s7; a result is valid once its box has
//    passed all seven. One box per clock while the result side is ready:
//    every stage holds its own valid bit and loads whenever it is empty or
//    the stage after it moves.
//  - A stall at the result side fills the pipeline bubble by bubble; box.ready
//    drops only once all seven stages hold items. Nothing is lost or repeated.
// Reset:
//  - arst_n clears all valid bits and sets the registers to origin 0,
//    reciprocal 1.0, interval [0, largest positive value].
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_unit #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rbsi_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [COORD_WIDTH-1:0]           cfg_data,
	rbsi_box_if.sink                         box,
	rbsi_result_if.source                    result
);
	import rbsi_pkg::*;

	localparam int W = COORD_WIDTH;
	localparam logic [W-1:0] INV_ONE  = W'(1) << FRAC_BITS;
	localparam logic [W-1:0] T_MAXPOS = {1'b0, {(W-1){1'b1}}};
	localparam int NSTG = 7;

	// ---- ray registers ----
	logic signed [W-1:0] origin_q [3];
	logic signed [W-1:0] inv_dir_q [3];
	logic signed [W-1:0] t_start_q;
	logic signed [W-1:0] t_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				origin_q[a]  <= '0;
				inv_dir_q[a] <= INV_ONE;
			end
			t_start_q <= '0;
			t_end_q   <= T_MAXPOS;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_X:       origin_q[0]  <= cfg_data;
				REG_ORIGIN_Y:       origin_q[1]  <= cfg_data;
				REG_ORIGIN_Z:       origin_q[2]  <= cfg_data;
				REG_INV_DIR_X:      inv_dir_q[0] <= cfg_data;
				REG_INV_DIR_Y:      inv_dir_q[1] <= cfg_data;
				REG_INV_DIR_Z:      inv_dir_q[2] <= cfg_data;
				REG_INTERVAL_START: t_start_q    <= cfg_data;
				REG_INTERVAL_END:   t_end_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---- pipeline flow control ----
	// stage k loads when empty or when stage k+1 loads; last stage frees on ready
	logic [NSTG:1] vld_q;
	logic [NSTG:1] load;
	slab_en_t      slab_en;
	merge_en_t     merge_en;

	always_comb begin
		load[NSTG] = !vld_q[NSTG] || result.ready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			load[k] = !vld_q[k] || load[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (load[1]) begin
				vld_q[1] <= box.valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (load[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign slab_en  = '{s1: load[1], s2: load[2], s3: load[3], s4: load[4]};
	assign merge_en = '{s5: load[5], s6: load[6], s7: load[7]};
	assign box.ready = load[1];

	// ---- per-axis slab products, stages 1..4 ----
	logic signed [W-1:0] bmin [3];
	logic signed [W-1:0] bmax [3];
	logic signed [W-1:0] t_lo [3];
	logic signed [W-1:0] t_hi [3];

	assign bmin[0] = box.box_min_x;
	assign bmin[1] = box.box_min_y;
	assign bmin[2] = box.box_min_z;
	assign bmax[0] = box.box_max_x;
	assign bmax[1] = box.box_max_y;
	assign bmax[2] = box.box_max_z;

	for (genvar a = 0; a < 3; a++) begin : g_axis
		rbsi_slab #(
			.COORD_WIDTH(COORD_WIDTH),
			.FRAC_BITS  (FRAC_BITS)
		) u_slab (
			.clk    (clk),
			.en     (slab_en),
			.bmin   (bmin[a]),
			.bmax   (bmax[a]),
			.origin (origin_q[a]),
			.inv_dir(inv_dir_q[a]),
			.t_lo_s4(t_lo[a]),
			.t_hi_s4(t_hi[a])
		);
	end

	// ---- interval merge and output register, stages 5..7 ----
	rbsi_merge #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_merge (
		.clk      (clk),
		.en       (merge_en),
		.lo_x     (t_lo[0]),
		.hi_x     (t_hi[0]),
		.lo_y     (t_lo[1]),
		.hi_y     (t_hi[1]),
		.lo_z     (t_lo[2]),
		.hi_z     (t_hi[2]),
		.t_start  (t_start_q),
		.t_end    (t_end_q),
		.hit_s7   (result.hit),
		.t_near_s7(result.t_near),
		.t_far_s7 (result.t_far)
	);

	assign result.valid = vld_q[NSTG];

endmodule

[test/ray_box_slab_intersect_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_unit_tb
// Self-checking bench for the ray / box slab intersection unit. A ray is
// loaded through the register port, boxes stream in, and every hit/interval
// item coming back is compared field by field against a bit-exact slab
// predictor. Covers directed corner cases (touching slabs, interval ties,
// negative and zero reciprocals, saturation, inverted boxes), a long output
// stall that backs up the pipeline, and randomized rays and boxes with random
// gaps on both channels.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_unit_tb;

	import rbsi_pkg::*;

	localparam int CW           = 32;
	localparam int FB           = 16;
	localparam int PIPE_DEPTH   = 7;       // number of register stages in the unit
	localparam int LIMIT_CYCLES = 200000;  // watchdog, far above the slowest run

	localparam logic signed [CW-1:0] MAX_Q = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] MIN_Q = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] ONE_Q = 1 << FB;

	typedef struct packed {
		logic [2:0][CW-1:0] bmin;  // index 0 = x, 1 = y, 2 = z
		logic [2:0][CW-1:0] bmax;
	} box_t;

	typedef struct packed {
		logic                 hit;
		logic signed [CW-1:0] t_near;
		logic signed [CW-1:0] t_far;
	} hit_result_t;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          cfg_we;
	logic [2:0]    cfg_index;
	logic [CW-1:0] cfg_data;

	rbsi_box_if    #(.COORD_WIDTH(CW)) box_ch ();
	rbsi_result_if #(.COORD_WIDTH(CW)) res_ch ();

	ray_box_slab_intersect_unit #(
		.COORD_WIDTH(CW),
		.FRAC_BITS  (FB)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.box      (box_ch),
		.result   (res_ch)
	);

	// Our copy of the ray registers, starting from the reset values.
	logic signed [CW-1:0] ray_origin [3] = '{0, 0, 0};
	logic signed [CW-1:0] ray_recip  [3] = '{ONE_Q, ONE_Q, ONE_Q};
	logic signed [CW-1:0] span_start = '0;
	logic signed [CW-1:0] span_end   = MAX_Q;

	hit_result_t pending_hits [$];  // predicted results, oldest first

	int errors      = 0;
	int boxes_in    = 0;
	int hits_seen   = 0;
	int misses_seen = 0;
	int rays_loaded = 0;
	int cycle_count = 0;
	int hold_req    = 0;    // one-shot long stall request for the receiver
	bit no_gaps     = 1'b0; // both sides run without idling while set

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// (bound - org) * recip >> FB, truncated toward zero, then saturated.
	// Work on magnitudes so the shift truncates toward zero, not toward -inf.
	function automatic logic signed [CW-1:0] slab_param(input logic signed [CW-1:0] bound,
			input logic signed [CW-1:0] org, input logic signed [CW-1:0] recip);
		logic signed [CW:0] delta;
		logic [CW:0]        delta_mag;
		logic [CW-1:0]      recip_mag;
		logic [2*CW:0]      scaled;
		logic [2*CW:0]      clamp;
		logic               neg;
		delta     = {bound[CW-1], bound} - {org[CW-1], org};
		neg       = delta[CW] ^ recip[CW-1];
		delta_mag = delta[CW] ? -delta : delta;
		recip_mag = recip[CW-1] ? -recip : recip;
		scaled    = delta_mag * recip_mag;
		scaled    = scaled >> FB;
		// negative side can reach one further (most negative value)
		clamp         = '0;
		clamp[CW-1]   = 1'b1;
		if (!neg)
			clamp = clamp - 1;
		if (scaled > clamp)
			scaled = clamp;
		return neg ? -scaled[CW-1:0] : scaled[CW-1:0];
	endfunction

	function automatic hit_result_t slab_test(input box_t b);
		logic signed [CW-1:0] lo [3];
		logic signed [CW-1:0] hi [3];
		logic signed [CW-1:0] near_b;
		logic signed [CW-1:0] far_b;
		logic signed [CW-1:0] t_in;
		logic signed [CW-1:0] t_out;
		hit_result_t          r;
		logic                 hit;
		for (int ax = 0; ax < 3; ax++) begin
			// negative reciprocal: the max bound is crossed first
			if (ray_recip[ax] < 0) begin
				near_b = $signed(b.bmax[ax]);
				far_b  = $signed(b.bmin[ax]);
			end else begin
				near_b = $signed(b.bmin[ax]);
				far_b  = $signed(b.bmax[ax]);
			end
			lo[ax] = slab_param(near_b, ray_origin[ax], ray_recip[ax]);
			hi[ax] = slab_param(far_b, ray_origin[ax], ray_recip[ax]);
		end
		t_in  = lo[0];
		t_out = hi[0];
		hit   = 1'b1;
		for (int ax = 1; ax < 3; ax++) begin
			if (hit) begin
				if (t_in > hi[ax] || lo[ax] > t_out) begin
					hit = 1'b0;  // slabs disjoint, early out
				end else begin
					if (lo[ax] > t_in)
						t_in = lo[ax];
					if (hi[ax] < t_out)
						t_out = hi[ax];
				end
			end
		end
		if (hit && !(t_in < span_end && t_out > span_start))
			hit = 1'b0;
		r.hit    = hit;
		r.t_near = hit ? t_in : span_start;
		r.t_far  = hit ? t_out : span_end;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Monitor and scoreboard: predict on box accept, check on result accept
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : score
		box_t        b;
		hit_result_t exp_r;
		if (arst_n) begin
			if (box_ch.valid && box_ch.ready) begin
				b.bmin = {box_ch.box_min_z, box_ch.box_min_y, box_ch.box_min_x};
				b.bmax = {box_ch.box_max_z, box_ch.box_max_y, box_ch.box_max_x};
				pending_hits.push_back(slab_test(b));
				boxes_in++;
			end
			if (res_ch.valid && res_ch.ready) begin
				if (res_ch.hit)
					hits_seen++;
				else
					misses_seen++;
				if (pending_hits.size() == 0) begin
					$display("%0t: unexpected result item: hit=%0b t_near=%0d t_far=%0d",
						$time, res_ch.hit, res_ch.t_near, res_ch.t_far);
					errors++;
				end else begin
					exp_r = pending_hits.pop_front();
					if (res_ch.hit !== exp_r.hit) begin
						$display("%0t: hit mismatch: expected %0b, got %0b",
							$time, exp_r.hit, res_ch.hit);
						errors++;
					end
					if (res_ch.t_near !== exp_r.t_near) begin
						$display("%0t: t_near mismatch: expected %0d, got %0d",
							$time, exp_r.t_near, res_ch.t_near);
						errors++;
					end
					if (res_ch.t_far !== exp_r.t_far) begin
						$display("%0t: t_far mismatch: expected %0d, got %0d",
							$time, exp_r.t_far, res_ch.t_far);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding",
				$time, cycle_count, pending_hits.size());
			$display("ray_box_slab_intersect_unit test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Result receiver: a random stall before each item (none while no_gaps is
	// set), or one long hold when a test asks for it. The hold is counted here, in cycles.
	// ------------------------------------------------------------------------
	initial begin : receiver
		int stall;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req > 0) begin
				stall    = hold_req;
				hold_req = 0;
			end else begin
				stall = no_gaps ? 0 : $urandom_range(0, 3);
			end
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!(res_ch.valid && res_ch.ready));
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic logic signed [CW-1:0] fx(input int n);
		return n <<< FB;
	endfunction

	function automatic logic [2:0][CW-1:0] xyz(input logic [CW-1:0] x, y, z);
		return {z, y, x};
	endfunction

	function automatic box_t make_box(input logic [CW-1:0] x0, y0, z0, x1, y1, z1);
		box_t b;
		b.bmin = xyz(x0, y0, z0);
		b.bmax = xyz(x1, y1, z1);
		return b;
	endfunction

	// Called at a rising edge; leaves cfg_we high, load_ray drops it.
	task automatic write_reg(input cfg_reg_t idx, input logic [CW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_ORIGIN_X:       ray_origin[0] = val;
			REG_ORIGIN_Y:       ray_origin[1] = val;
			REG_ORIGIN_Z:       ray_origin[2] = val;
			REG_INV_DIR_X:      ray_recip[0]  = val;
			REG_INV_DIR_Y:      ray_recip[1]  = val;
			REG_INV_DIR_Z:      ray_recip[2]  = val;
			REG_INTERVAL_START: span_start    = val;
			REG_INTERVAL_END:   span_end      = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Only called with nothing in flight.
	task automatic load_ray(input logic [2:0][CW-1:0] org, input logic [2:0][CW-1:0] rcp,
			input logic [CW-1:0] t_lo, input logic [CW-1:0] t_hi);
		write_reg(REG_ORIGIN_X, org[0]);
		write_reg(REG_ORIGIN_Y, org[1]);
		write_reg(REG_ORIGIN_Z, org[2]);
		write_reg(REG_INV_DIR_X, rcp[0]);
		write_reg(REG_INV_DIR_Y, rcp[1]);
		write_reg(REG_INV_DIR_Z, rcp[2]);
		write_reg(REG_INTERVAL_START, t_lo);
		write_reg(REG_INTERVAL_END, t_hi);
		cfg_we <= 1'b0;
		rays_loaded++;
	endtask

	// Offers one box item, after a random gap, and returns at its accept edge
	// with valid still high so back-to-back items stream without a bubble.
	task automatic send_box(input box_t b);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			box_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		box_ch.valid     <= 1'b1;
		box_ch.box_min_x <= b.bmin[0];
		box_ch.box_min_y <= b.bmin[1];
		box_ch.box_min_z <= b.bmin[2];
		box_ch.box_max_x <= b.bmax[0];
		box_ch.box_max_y <= b.bmax[1];
		box_ch.box_max_z <= b.bmax[2];
		do
			@(posedge clk);
		while (!box_ch.ready);
	endtask

	// Stop offering, let every predicted item come back, then wait out the
	// pipeline depth so the unit is idle before registers change.
	task automatic wait_for_results();
		box_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Ray as it comes out of reset: origin 0, reciprocal 1.0, interval [0, max].
	task automatic test_reset_ray();
		send_box(make_box(fx(1), fx(1), fx(1), fx(2), fx(2), fx(2)));
		send_box(make_box(fx(-5), fx(-5), fx(-5), fx(-3), fx(-3), fx(-3)));  // behind
		wait_for_results();
	endtask

	// With reciprocal 1.0 and origin 0 the slab parameters equal the bounds.
	task automatic test_ties();
		load_ray(xyz(0, 0, 0), xyz(ONE_Q, ONE_Q, ONE_Q), 0, fx(5));
		// x and y slabs touch at 3: still overlapping
		send_box(make_box(fx(1), fx(3), fx(0), fx(3), fx(4), fx(4)));
		// entry exactly at interval end: miss
		send_box(make_box(fx(5), fx(5), fx(5), fx(6), fx(6), fx(6)));
		// exit exactly at interval start: miss
		send_box(make_box(fx(-2), fx(-2), fx(-2), 0, 0, 0));
		// x/y disjoint, and y-overlapping but z disjoint
		send_box(make_box(fx(0), fx(2), fx(0), fx(1), fx(3), fx(4)));
		send_box(make_box(fx(0), fx(0), fx(4), fx(3), fx(3), fx(5)));
		wait_for_results();
	endtask

	// Negative reciprocal swaps near and far bounds.
	task automatic test_negative_recip();
		load_ray(xyz(0, 0, 0), xyz(-ONE_Q, fx(-2), ONE_Q), MIN_Q, MAX_Q);
		send_box(make_box(fx(-2), fx(-2), fx(1), fx(-1), fx(-1), fx(3)));
		send_box(make_box(fx(-2), fx(-2), fx(-2), fx(-1), fx(-1), fx(-1)));
		send_box(make_box(fx(1), fx(-3), fx(-7), fx(4), fx(9), fx(2)));
		wait_for_results();
	endtask

	// Zero reciprocal: x slab collapses to [0, 0].
	task automatic test_zero_recip();
		load_ray(xyz(fx(3), 0, 0), xyz(0, ONE_Q, ONE_Q), MIN_Q, MAX_Q);
		send_box(make_box(fx(-9), fx(-1), fx(-1), fx(-8), fx(1), fx(1)));
		send_box(make_box(fx(-9), fx(1), fx(1), fx(-8), fx(2), fx(2)));
		wait_for_results();
	endtask

	// min above max on some axis
	task automatic test_inverted_box();
		load_ray(xyz(0, 0, 0), xyz(ONE_Q, ONE_Q, ONE_Q), 0, MAX_Q);
		send_box(make_box(fx(3), fx(3), fx(3), fx(1), fx(1), fx(1)));
		send_box(make_box(fx(1), fx(1), fx(6), fx(8), fx(8), fx(2)));
		wait_for_results();
	endtask

	// Extreme origins, reciprocals, bounds and intervals: products saturate.
	task automatic test_saturation();
		load_ray(xyz(MIN_Q, MAX_Q, 0), xyz(MAX_Q, MIN_Q, MAX_Q), MIN_Q, MAX_Q);
		send_box(make_box(MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q));
		send_box(make_box(MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q, MIN_Q));
		send_box(make_box(MIN_Q, MIN_Q, MIN_Q, MAX_Q, MAX_Q, MAX_Q));
		wait_for_results();
		// interval turned inside out: nothing can hit
		load_ray(xyz(MAX_Q, MIN_Q, MAX_Q), xyz(MIN_Q, MAX_Q, 0), MAX_Q, MIN_Q);
		send_box(make_box(MIN_Q, MIN_Q, MIN_Q, MAX_Q, MAX_Q, MAX_Q));
		send_box(make_box(0, 0, 0, ONE_Q, ONE_Q, ONE_Q));
		wait_for_results();
	endtask

	// Receiver holds off well past the pipeline depth while boxes keep
	// coming, so box.ready has to drop and nothing may be lost or doubled.
	task automatic test_backpressure();
		box_t b;
		load_ray(xyz(0, 0, 0), xyz(ONE_Q, ONE_Q, ONE_Q), 0, MAX_Q);
		no_gaps  = 1'b1;
		hold_req = 60;
		for (int i = 0; i < 30; i++) begin
			b = make_box(fx(i), fx(i), fx(i), fx(i + 2), fx(i + 3), fx(i + 1));
			send_box(b);
		end
		wait_for_results();
		no_gaps = 1'b0;
	endtask

	function automatic logic signed [CW-1:0] pick_recip();
		case ($urandom_range(0, 9))
			0:       return MAX_Q;
			1:       return MIN_Q;
			2:       return 0;
			3:       return $urandom();
			default: return $signed($urandom_range(0, 8 << FB)) - fx(4);  // +/-4.0
		endcase
	endfunction

	function automatic logic signed [CW-1:0] pick_origin();
		case ($urandom_range(0, 9))
			0:       return MAX_Q;
			1:       return MIN_Q;
			2:       return $urandom();
			default: return $signed($urandom_range(0, 128 << FB)) - fx(64);
		endcase
	endfunction

	// Random rays; most boxes sit around the origin so that a fair share
	// hits, the rest are raw random words (inverted boxes included).
	task automatic test_random_rays(input int n_rays, input int per_ray);
		logic [2:0][CW-1:0]   org;
		logic [2:0][CW-1:0]   rcp;
		logic signed [CW-1:0] t_lo;
		logic signed [CW-1:0] t_hi;
		logic signed [CW-1:0] ctr;
		logic signed [CW-1:0] half;
		box_t                 b;
		for (int k = 0; k < n_rays; k++) begin
			for (int ax = 0; ax < 3; ax++) begin
				org[ax] = pick_origin();
				rcp[ax] = pick_recip();
			end
			case ($urandom_range(0, 3))
				0:       t_lo = MIN_Q;
				1:       t_lo = $urandom();
				2:       t_lo = $signed($urandom_range(0, 16 << FB)) - fx(8);
				default: t_lo = 0;
			endcase
			case ($urandom_range(0, 3))
				0:       t_hi = $signed($urandom_range(0, 64 << FB));
				1:       t_hi = $urandom();
				default: t_hi = MAX_Q;
			endcase
			load_ray(org, rcp, t_lo, t_hi);
			no_gaps = (k % 3 == 2);  // every third ray streams with no idling
			for (int j = 0; j < per_ray; j++) begin
				if ($urandom_range(0, 3) == 0) begin
					b.bmin = {$urandom(), $urandom(), $urandom()};
					b.bmax = {$urandom(), $urandom(), $urandom()};
				end else begin
					for (int ax = 0; ax < 3; ax++) begin
						ctr  = $signed(org[ax]) + $signed($urandom_range(0, 64 << FB)) - fx(32);
						half = $urandom_range(0, 16 << FB);
						b.bmin[ax] = ctr - half;
						b.bmax[ax] = ctr + half;
					end
				end
				send_box(b);
			end
			wait_for_results();
		end
		no_gaps = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		box_ch.valid     = 1'b0;
		box_ch.box_min_x = '0;
		box_ch.box_min_y = '0;
		box_ch.box_min_z = '0;
		box_ch.box_max_x = '0;
		box_ch.box_max_y = '0;
		box_ch.box_max_z = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_ray();
		test_ties();
		test_negative_recip();
		test_zero_recip();
		test_inverted_box();
		test_saturation();
		test_backpressure();
		test_random_rays(8, 100);
		wait_for_results();

		$display("Covered %0d boxes against %0d loaded rays (%0d hits, %0d misses),",
			boxes_in, rays_loaded, hits_seen, misses_seen);
		$display("including saturated products, interval ties and a long output stall.");
		if (errors == 0) begin
			$display("ray_box_slab_intersect_unit test passed");
		end else begin
			$display("%0d mismatches", errors);
			$display("ray_box_slab_intersect_unit test failed");
		end
		$finish;
	end

endmodule
